/* design/crfm_pkg.sv */
package crfm_pkg;

    // field widths
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned SDIST_W   = 21;
    localparam int unsigned DIST_W    = 20;
    localparam int unsigned VEL_W     = 16;
    localparam int unsigned CLASS_W   = 8;
    localparam int unsigned NCLASS_W  = 9;
    localparam int unsigned TRACK_W   = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned RISK_W    = 3;
    localparam int unsigned CFG16_W   = 16;
    localparam int unsigned CFG20_W   = 20;
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned APB_DW    = 32;

    // serial datapath sizing
    localparam int unsigned P125_W    = 23;   // 125 * ppm
    localparam int unsigned P625_W    = 26;   // 625 * ppm
    localparam int unsigned THR_W     = 32;   // 64000 * ppm
    localparam int unsigned NUM_ZEROS = 11;   // 1280000 * ppm = 625 * ppm << 11
    localparam int unsigned THR_ZEROS = 9;    // 64000 * ppm = 125 * ppm << 9
    localparam int unsigned PROD_W    = 35;   // v * d
    localparam int unsigned DIVD_W    = P625_W + NUM_ZEROS;
    localparam int unsigned MAG_W     = VEL_W - 1;
    localparam int unsigned MUL_STEPS = MAG_W;
    localparam int unsigned DIV_STEPS = DIVD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DIST_W-1:0]   TTC_NONE_MS     = 20'd999000;
    localparam logic [DIST_W-1:0]   DIST_DANGER_MM  = 20'd1500;
    localparam logic [DIST_W-1:0]   DIST_WARNING_MM = 20'd3000;
    localparam logic signed [NCLASS_W-1:0] NCLASS_NONE = -9'sd1;

    localparam logic [RISK_W-1:0] RISK_SAFE     = 3'd0;
    localparam logic [RISK_W-1:0] RISK_CAUTION  = 3'd1;
    localparam logic [RISK_W-1:0] RISK_WARNING  = 3'd2;
    localparam logic [RISK_W-1:0] RISK_DANGER   = 3'd3;
    localparam logic [RISK_W-1:0] RISK_CRITICAL = 3'd4;

    // register reset values
    localparam logic [CFG16_W-1:0] PPM_RST       = 16'd100;
    localparam logic [CFG16_W-1:0] HOLD_RST      = 16'd2000;
    localparam logic [CFG20_W-1:0] TTC_CRIT_RST  = 20'd1200;
    localparam logic [CFG20_W-1:0] TTC_DANG_RST  = 20'd2500;
    localparam logic [CFG20_W-1:0] TTC_WARN_RST  = 20'd4500;
    localparam logic [CFG20_W-1:0] TTC_CAUT_RST  = 20'd7000;
    localparam logic [CFG20_W-1:0] DIST_CRIT_RST = 20'd800;
    localparam logic [CFG20_W-1:0] DIST_CAUT_RST = 20'd5000;
    localparam logic [P125_W-1:0]  P125_RST      = 23'd12500;
    localparam logic [P625_W-1:0]  P625_RST      = 26'd62500;

    typedef enum logic [KIND_W-1:0] {
        KIND_OBJECT    = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_FORCE_OFF = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_PPM,
        REG_HOLD,
        REG_TTC_CRIT,
        REG_TTC_DANG,
        REG_TTC_WARN,
        REG_TTC_CAUT,
        REG_DIST_CRIT,
        REG_DIST_CAUT
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_ACCUM,
        S_CLOSE
    } t_state;

    typedef struct packed {
        logic [CFG16_W-1:0] ppm;
        logic [CFG16_W-1:0] hold;
        logic [CFG20_W-1:0] ttc_crit;
        logic [CFG20_W-1:0] ttc_dang;
        logic [CFG20_W-1:0] ttc_warn;
        logic [CFG20_W-1:0] ttc_caut;
        logic [CFG20_W-1:0] dist_crit;
        logic [CFG20_W-1:0] dist_caut;
        logic [P625_W-1:0]  p625;
        logic [THR_W-1:0]   thr;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic accum;
        logic close;
        logic force_off;
    } t_frame_ctl;

endpackage

/* design/crfm_if.sv */
interface crfm_in_if;
    import crfm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [SDIST_W-1:0] distance_mm;
    logic signed [VEL_W-1:0]   pixel_velocity;
    logic [CLASS_W-1:0]        obj_class;
    logic [TRACK_W-1:0]        obj_track;
    logic                      last_in_frame;
    logic [TIME_W-1:0]         now_ms;

    modport source (
        output valid, kind, distance_mm, pixel_velocity, obj_class, obj_track,
               last_in_frame, now_ms,
        input  ready
    );
    modport sink (
        input  valid, kind, distance_mm, pixel_velocity, obj_class, obj_track,
               last_in_frame, now_ms,
        output ready
    );
endinterface

interface crfm_out_if;
    import crfm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [RISK_W-1:0]          max_risk;
    logic [DIST_W-1:0]          min_ttc_ms;
    logic [DIST_W-1:0]          nearest_distance_mm;
    logic signed [NCLASS_W-1:0] nearest_class;
    logic [TRACK_W-1:0]         nearest_track;
    logic                       alarm_active;

    modport source (
        output valid, max_risk, min_ttc_ms, nearest_distance_mm, nearest_class,
               nearest_track, alarm_active,
        input  ready
    );
    modport sink (
        input  valid, max_risk, min_ttc_ms, nearest_distance_mm, nearest_class,
               nearest_track, alarm_active,
        output ready
    );
endinterface

/* design/crfm_cfg.sv */
module crfm_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crfm_pkg::APB_AW-1:0]  paddr,
    input  logic [crfm_pkg::APB_DW-1:0]  pwdata,
    output logic [crfm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output crfm_pkg::t_cfg               o_cfg
);
    import crfm_pkg::*;

    logic [CFG16_W-1:0] r_ppm, r_hold;
    logic [CFG20_W-1:0] r_ttc_crit, r_ttc_dang, r_ttc_warn, r_ttc_caut;
    logic [CFG20_W-1:0] r_dist_crit, r_dist_caut;
    logic [P125_W-1:0]  r_p125;
    logic [P625_W-1:0]  r_p625;

    logic               wr_en;
    t_reg_idx           reg_idx;
    logic [CFG16_W-1:0] w16;
    logic [CFG20_W-1:0] w20;
    logic [P125_W-1:0]  n_p125;
    logic [P625_W-1:0]  n_p625;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w16     = pwdata[CFG16_W-1:0];
    assign w20     = pwdata[CFG20_W-1:0];

    // scale products are formed at write time: 125 = 128 - 2 - 1, 625 = 5 * 125
    assign n_p125 = {w16, 7'b0} - {6'b0, w16, 1'b0} - {7'b0, w16};
    assign n_p625 = {1'b0, n_p125, 2'b0} + {3'b0, n_p125};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppm       <= PPM_RST;
            r_hold      <= HOLD_RST;
            r_ttc_crit  <= TTC_CRIT_RST;
            r_ttc_dang  <= TTC_DANG_RST;
            r_ttc_warn  <= TTC_WARN_RST;
            r_ttc_caut  <= TTC_CAUT_RST;
            r_dist_crit <= DIST_CRIT_RST;
            r_dist_caut <= DIST_CAUT_RST;
            r_p125      <= P125_RST;
            r_p625      <= P625_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PPM: begin
                    r_ppm  <= w16;
                    r_p125 <= n_p125;
                    r_p625 <= n_p625;
                end
                REG_HOLD:      r_hold      <= w16;
                REG_TTC_CRIT:  r_ttc_crit  <= w20;
                REG_TTC_DANG:  r_ttc_dang  <= w20;
                REG_TTC_WARN:  r_ttc_warn  <= w20;
                REG_TTC_CAUT:  r_ttc_caut  <= w20;
                REG_DIST_CRIT: r_dist_crit <= w20;
                REG_DIST_CAUT: r_dist_caut <= w20;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PPM:       prdata = {16'b0, r_ppm};
            REG_HOLD:      prdata = {16'b0, r_hold};
            REG_TTC_CRIT:  prdata = {12'b0, r_ttc_crit};
            REG_TTC_DANG:  prdata = {12'b0, r_ttc_dang};
            REG_TTC_WARN:  prdata = {12'b0, r_ttc_warn};
            REG_TTC_CAUT:  prdata = {12'b0, r_ttc_caut};
            REG_DIST_CRIT: prdata = {12'b0, r_dist_crit};
            REG_DIST_CAUT: prdata = {12'b0, r_dist_caut};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.ppm       = r_ppm;
    assign o_cfg.hold      = r_hold;
    assign o_cfg.ttc_crit  = r_ttc_crit;
    assign o_cfg.ttc_dang  = r_ttc_dang;
    assign o_cfg.ttc_warn  = r_ttc_warn;
    assign o_cfg.ttc_caut  = r_ttc_caut;
    assign o_cfg.dist_crit = r_dist_crit;
    assign o_cfg.dist_caut = r_dist_caut;
    assign o_cfg.p625      = r_p625;
    assign o_cfg.thr       = {r_p125, {THR_ZEROS{1'b0}}};

endmodule

/* design/crfm_ttc.sv */
module crfm_ttc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [crfm_pkg::DIST_W-1:0]       i_dist,
    input  logic signed [crfm_pkg::VEL_W-1:0] i_vel,
    input  crfm_pkg::t_cfg                    i_cfg,
    output logic                              o_done,
    output logic [crfm_pkg::DIST_W-1:0]       o_ttc
);
    import crfm_pkg::*;

    logic                 r_busy, r_fin, r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [PROD_W:0]      r_prod;     // {partial high, multiplier low}
    logic [DIVD_W-1:0]    r_divd;
    logic [MAG_W-1:0]     r_rem;
    logic [DIST_W-1:0]    r_quo;
    logic                 r_ovf;
    logic [DIST_W-1:0]    r_dist;
    logic [VEL_W-1:0]     r_vel;
    logic [DIST_W-1:0]    r_ttc;

    logic [DIST_W:0]      mul_sum;
    logic [PROD_W:0]      n_prod;
    logic [MAG_W:0]       rem_sh, divisor, rem_sub;
    logic                 rem_ge;
    logic [MAG_W-1:0]     n_rem;
    logic                 no_hit;
    logic [DIST_W-1:0]    n_ttc;
    logic                 last_step;

    // shift-add multiplier, one velocity bit a cycle
    assign mul_sum = r_prod[PROD_W:MAG_W] + (r_prod[0] ? {1'b0, r_dist} : '0);
    assign n_prod  = {1'b0, mul_sum, r_prod[MAG_W-1:1]};

    // restoring divider, one quotient bit a cycle
    assign rem_sh  = {r_rem, r_divd[DIVD_W-1]};
    assign divisor = {1'b0, r_vel[MAG_W-1:0]};
    assign rem_ge  = rem_sh >= divisor;
    assign rem_sub = rem_sh - divisor;
    assign n_rem   = rem_ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];

    // receding, standing, zero distance or scale, slower than 50 mm/s or over the cap: no collision
    assign no_hit = r_vel[VEL_W-1] || (r_vel == '0) || (r_dist == '0) ||
                    (i_cfg.ppm == '0) ||
                    (r_prod[PROD_W-1:0] < {3'b0, i_cfg.thr}) ||
                    r_ovf || (r_quo > TTC_NONE_MS);
    assign n_ttc  = no_hit ? TTC_NONE_MS : r_quo;

    assign last_step = r_busy && !i_start && (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dist <= i_dist;
            r_vel  <= i_vel;
            r_prod <= {{(PROD_W + 1 - MAG_W){1'b0}}, i_vel[MAG_W-1:0]};
            r_divd <= {i_cfg.p625, {NUM_ZEROS{1'b0}}};
            r_rem  <= '0;
            r_quo  <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_divd <= {r_divd[DIVD_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quo  <= {r_quo[DIST_W-2:0], rem_ge};
            r_ovf  <= r_ovf | r_quo[DIST_W-1];
            if (r_cnt < CNT_W'(MUL_STEPS)) begin
                r_prod <= n_prod;
            end
        end
        if (r_fin) begin
            r_ttc <= n_ttc;
        end
    end

    assign o_done = r_done;
    assign o_ttc  = r_ttc;

endmodule

/* design/crfm_frame.sv */
module crfm_frame (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crfm_pkg::t_frame_ctl          i_ctl,
    input  crfm_pkg::t_cfg                i_cfg,
    input  logic [crfm_pkg::DIST_W-1:0]   i_dist,
    input  logic [crfm_pkg::DIST_W-1:0]   i_ttc,
    input  logic [crfm_pkg::CLASS_W-1:0]  i_class,
    input  logic [crfm_pkg::TRACK_W-1:0]  i_track,
    input  logic [crfm_pkg::TIME_W-1:0]   i_now,
    output logic                          o_slot_free,
    crfm_out_if.source                    o_result
);
    import crfm_pkg::*;

    logic [RISK_W-1:0]          r_max;
    logic [DIST_W-1:0]          r_min_ttc;
    logic [DIST_W-1:0]          r_near_dist;
    logic signed [NCLASS_W-1:0] r_near_class;
    logic [TRACK_W-1:0]         r_near_track;
    logic                       r_flag;
    logic [TIME_W-1:0]          r_last_crit;
    logic                       r_out_valid;
    logic [RISK_W-1:0]          r_out_max;
    logic [DIST_W-1:0]          r_out_ttc;
    logic [DIST_W-1:0]          r_out_dist;
    logic signed [NCLASS_W-1:0] r_out_class;
    logic [TRACK_W-1:0]         r_out_track;
    logic                       r_out_flag;

    logic [RISK_W-1:0]          risk_t, risk_d, risk;
    logic [TIME_W-1:0]          elapsed;
    logic                       n_flag;

    always_comb begin
        if (i_ttc < i_cfg.ttc_crit)      risk_t = RISK_CRITICAL;
        else if (i_ttc < i_cfg.ttc_dang) risk_t = RISK_DANGER;
        else if (i_ttc < i_cfg.ttc_warn) risk_t = RISK_WARNING;
        else if (i_ttc < i_cfg.ttc_caut) risk_t = RISK_CAUTION;
        else                             risk_t = RISK_SAFE;

        if (i_dist < i_cfg.dist_crit)    risk_d = RISK_CRITICAL;
        else if (i_dist < DIST_DANGER_MM)  risk_d = RISK_DANGER;
        else if (i_dist < DIST_WARNING_MM) risk_d = RISK_WARNING;
        else if (i_dist < i_cfg.dist_caut) risk_d = RISK_CAUTION;
        else                             risk_d = RISK_SAFE;

        risk = (risk_t > risk_d) ? risk_t : risk_d;
    end

    // wrapping elapsed time since last critical frame
    assign elapsed = i_now - r_last_crit;

    always_comb begin
        if (r_max == RISK_CRITICAL) begin
            n_flag = 1'b1;
        end else if (r_flag && (elapsed >= {16'b0, i_cfg.hold})) begin
            n_flag = 1'b0;
        end else begin
            n_flag = r_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= RISK_SAFE;
            r_min_ttc    <= TTC_NONE_MS;
            r_near_dist  <= TTC_NONE_MS;
            r_near_class <= NCLASS_NONE;
            r_near_track <= '0;
            r_flag       <= 1'b0;
            r_last_crit  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.clear || i_ctl.close) begin
                r_max        <= RISK_SAFE;
                r_min_ttc    <= TTC_NONE_MS;
                r_near_dist  <= TTC_NONE_MS;
                r_near_class <= NCLASS_NONE;
                r_near_track <= '0;
            end else if (i_ctl.accum) begin
                if (risk > r_max) begin
                    r_max <= risk;
                end
                if (i_ttc < r_min_ttc) begin
                    r_min_ttc <= i_ttc;
                end
                if (i_dist < r_near_dist) begin
                    r_near_dist  <= i_dist;
                    r_near_class <= $signed({1'b0, i_class});
                    r_near_track <= i_track;
                end
            end

            if (i_ctl.force_off) begin
                r_flag <= 1'b0;
            end else if (i_ctl.close) begin
                r_flag <= n_flag;
                if (r_max == RISK_CRITICAL) begin
                    r_last_crit <= i_now;
                end
            end

            if (i_ctl.close) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.close) begin
            r_out_max   <= r_max;
            r_out_ttc   <= r_min_ttc;
            r_out_dist  <= r_near_dist;
            r_out_class <= r_near_class;
            r_out_track <= r_near_track;
            r_out_flag  <= n_flag;
        end
    end

    assign o_slot_free                  = !r_out_valid || o_result.ready;
    assign o_result.valid               = r_out_valid;
    assign o_result.max_risk            = r_out_max;
    assign o_result.min_ttc_ms          = r_out_ttc;
    assign o_result.nearest_distance_mm = r_out_dist;
    assign o_result.nearest_class       = r_out_class;
    assign o_result.nearest_track       = r_out_track;
    assign o_result.alarm_active        = r_out_flag;

endmodule

/* design/collision_risk_frame_monitor.sv */
// Flow: an object word with a valid distance passes, from its accept to the next accept,
//   through load, 37 divider steps, finish, done handoff and accumulate; a closing word adds
//   a close step that loads the result register once the result slot is free.
// Pacing: a new word is accepted only once the last one is done, set by the one-bit-a-cycle
//   divider over the 37-bit numerator; the 15-bit serial multiplier runs alongside it.
// Reset: synchronous, active low; registers to defaults, frame cleared, flag off.
module collision_risk_frame_monitor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    crfm_in_if.sink                      i_item,
    crfm_out_if.source                   o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crfm_pkg::APB_AW-1:0]  paddr,
    input  logic [crfm_pkg::APB_DW-1:0]  pwdata,
    output logic [crfm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import crfm_pkg::*;

    t_state             r_state, n_state;
    t_cfg               cfg;
    t_frame_ctl         ctl;
    logic               accept;
    logic               ttc_start, ttc_done, slot_free;
    logic [DIST_W-1:0]  ttc;

    // item fields held for the accumulate and close steps
    logic [DIST_W-1:0]  r_dist;
    logic [CLASS_W-1:0] r_class;
    logic [TRACK_W-1:0] r_track;
    logic               r_last;
    logic [TIME_W-1:0]  r_now;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;

    crfm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // serial multiply (speed check) and divide (time to collision)
    crfm_ttc u_ttc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ttc_start),
        .i_dist  (i_item.distance_mm[DIST_W-1:0]),
        .i_vel   (i_item.pixel_velocity),
        .i_cfg   (cfg),
        .o_done  (ttc_done),
        .o_ttc   (ttc)
    );

    // per-frame accumulators, emergency flag and result register
    crfm_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cfg       (cfg),
        .i_dist      (r_dist),
        .i_ttc       (ttc),
        .i_class     (r_class),
        .i_track     (r_track),
        .i_now       (r_now),
        .o_slot_free (slot_free),
        .o_result    (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dist  <= i_item.distance_mm[DIST_W-1:0];
            r_class <= i_item.obj_class;
            r_track <= i_item.obj_track;
            r_last  <= i_item.last_in_frame;
            r_now   <= i_item.now_ms;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    case (t_kind'(i_item.kind))
                        KIND_OBJECT: begin
                            // negative distance: skipped, may still close the frame
                            if (i_item.distance_mm[SDIST_W-1]) begin
                                n_state = i_item.last_in_frame ? S_CLOSE : S_IDLE;
                            end else begin
                                n_state = S_CALC;
                            end
                        end
                        KIND_EMPTY: n_state = S_CLOSE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CALC: begin
                if (ttc_done) begin
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM: n_state = r_last ? S_CLOSE : S_IDLE;
            S_CLOSE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl       = '0;
        ttc_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    case (t_kind'(i_item.kind))
                        KIND_OBJECT:    ttc_start     = !i_item.distance_mm[SDIST_W-1];
                        KIND_EMPTY:     ctl.clear     = 1'b1;
                        KIND_FORCE_OFF: ctl.force_off = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_ACCUM: ctl.accum = 1'b1;
            S_CLOSE: ctl.close = slot_free;
            default: ;
        endcase
    end

    // divider finishes only while an object waits on it
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ttc_done |-> (r_state == S_CALC))
        else $error("ttc done outside calc");

    a_risk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.max_risk <= RISK_CRITICAL))
        else $error("risk out of range");

    // a critical frame always leaves the flag set
    a_crit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.max_risk == RISK_CRITICAL))
        |-> o_result.alarm_active)
        else $error("critical frame without flag");

    // nearest class is none exactly when no nearest object was found
    a_nearest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.nearest_class == NCLASS_NONE) ==
                            (o_result.nearest_distance_mm == TTC_NONE_MS)))
        else $error("nearest class and distance disagree");

endmodule

/* test/tb_collision_risk_frame_monitor.sv */
`timescale 1ns / 1ps

module tb_collision_risk_frame_monitor;
    import crfm_pkg::*;

    localparam int HALF_PERIOD_NS = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 37;      // chance per cycle that a side idles
    localparam int DRAIN_CYCLES   = 60;      // covers the tail of an object word in the divider
    localparam int NUM_REGS       = 8;
    localparam int MAX_PRINTS     = 100;
    localparam int RUN_LIMIT_NS   = 10_000_000;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;   // not decoded by the block
    localparam int DIST_SKIP = -1;                      // depth failed
    localparam int DIST_TOP  = 1048575;                 // largest non-negative distance

    // one word on the object channel
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [SDIST_W-1:0] dist_mm;
        logic signed [VEL_W-1:0]   vel;
        logic [CLASS_W-1:0]        cls;
        logic [TRACK_W-1:0]        trk;
        logic                      last;
        logic [TIME_W-1:0]         now;
    } t_track_word;

    // one word on the result channel
    typedef struct packed {
        logic [RISK_W-1:0]          risk;
        logic [DIST_W-1:0]          ttc;
        logic [DIST_W-1:0]          near_dist;
        logic signed [NCLASS_W-1:0] near_cls;
        logic [TRACK_W-1:0]         near_trk;
        logic                       alarm;
    } t_frame_summary;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    crfm_in_if  item_bus ();
    crfm_out_if result_bus ();

    collision_risk_frame_monitor DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the register file, indexed by register code; 16-bit ones zero-extended.
    logic [CFG20_W-1:0] reg_shadow [NUM_REGS];

    // Frame accumulators and the latched emergency flag, as the block should hold them.
    logic [RISK_W-1:0]          acc_risk;
    logic [DIST_W-1:0]          acc_ttc;
    logic [DIST_W-1:0]          acc_dist;
    logic signed [NCLASS_W-1:0] acc_cls;
    logic [TRACK_W-1:0]         acc_trk;
    logic                       alarm_flag;
    logic [TIME_W-1:0]          last_crit_ms;

    t_frame_summary frame_summaries_due [$];   // expected frame results, oldest first

    int          mismatch_count;
    int          frames_seen;
    bit          steady_flow;    // both sides stop idling while set
    logic [TIME_W-1:0] wall_ms;  // running camera clock for now_ms

    always #(HALF_PERIOD_NS) i_clk = ~i_clk;

    // hard stop in case a word never gets through
    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // ---------------------------------------------------------------- predictor

    // Time to collision in ms. Approach speed is v*d/(1280*ppm) mm/s; under 50 mm/s
    // there is no collision. d/speed reduces to 1280000*ppm/v, floored and capped.
    function automatic logic [DIST_W-1:0] ttc_estimate(logic [DIST_W-1:0] d,
                                                       logic signed [VEL_W-1:0] v);
        longint unsigned ppm;
        longint unsigned mag;
        longint unsigned quot;
        ppm = reg_shadow[REG_PPM];
        if (v <= 0 || d == 0 || ppm == 0) return TTC_NONE_MS;
        mag = longint'(v);
        if (mag * d < 64'd64000 * ppm) return TTC_NONE_MS;
        quot = (64'd1280000 * ppm) / mag;
        return (quot > TTC_NONE_MS) ? TTC_NONE_MS : quot[DIST_W-1:0];
    endfunction

    // risk is the worse of the time grade and the distance grade
    function automatic logic [RISK_W-1:0] risk_grade(logic [DIST_W-1:0] ttc,
                                                     logic [DIST_W-1:0] d);
        logic [RISK_W-1:0] by_time;
        logic [RISK_W-1:0] by_dist;
        if (ttc < reg_shadow[REG_TTC_CRIT])      by_time = RISK_CRITICAL;
        else if (ttc < reg_shadow[REG_TTC_DANG]) by_time = RISK_DANGER;
        else if (ttc < reg_shadow[REG_TTC_WARN]) by_time = RISK_WARNING;
        else if (ttc < reg_shadow[REG_TTC_CAUT]) by_time = RISK_CAUTION;
        else                                     by_time = RISK_SAFE;
        if (d < reg_shadow[REG_DIST_CRIT])       by_dist = RISK_CRITICAL;
        else if (d < DIST_DANGER_MM)             by_dist = RISK_DANGER;
        else if (d < DIST_WARNING_MM)            by_dist = RISK_WARNING;
        else if (d < reg_shadow[REG_DIST_CAUT])  by_dist = RISK_CAUTION;
        else                                     by_dist = RISK_SAFE;
        return (by_time > by_dist) ? by_time : by_dist;
    endfunction

    function automatic void clear_frame();
        acc_risk = RISK_SAFE;
        acc_ttc  = TTC_NONE_MS;
        acc_dist = TTC_NONE_MS;
        acc_cls  = NCLASS_NONE;
        acc_trk  = '0;
    endfunction

    // Frame close: a critical frame latches the flag and stamps the time; otherwise
    // the flag drops once the hold time has passed (wrapping difference).
    function automatic void close_frame(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        t_frame_summary    summary;
        elapsed = now - last_crit_ms;
        if (acc_risk >= RISK_CRITICAL) begin
            alarm_flag   = 1'b1;
            last_crit_ms = now;
        end else if (alarm_flag && elapsed >= reg_shadow[REG_HOLD]) begin
            alarm_flag = 1'b0;
        end
        summary.risk      = acc_risk;
        summary.ttc       = acc_ttc;
        summary.near_dist = acc_dist;
        summary.near_cls  = acc_cls;
        summary.near_trk  = acc_trk;
        summary.alarm     = alarm_flag;
        frame_summaries_due.push_back(summary);
        clear_frame();
    endfunction

    function automatic void track_frame(t_track_word w);
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] ttc;
        logic [RISK_W-1:0] risk;
        case (w.kind)
            KIND_EMPTY: begin
                // empty frame drops what was gathered, then closes normally
                clear_frame();
                close_frame(w.now);
            end
            KIND_FORCE_OFF: begin
                alarm_flag = 1'b0;
            end
            KIND_OBJECT: begin
                // negative distance: object skipped, but may still close the frame
                if (!w.dist_mm[SDIST_W-1]) begin
                    d    = w.dist_mm[DIST_W-1:0];
                    ttc  = ttc_estimate(d, w.vel);
                    risk = risk_grade(ttc, d);
                    if (risk > acc_risk) acc_risk = risk;
                    if (ttc < acc_ttc) acc_ttc = ttc;
                    // above 999000 mm never wins against the reset value
                    if (d < acc_dist) begin
                        acc_dist = d;
                        acc_cls  = {1'b0, w.cls};
                        acc_trk  = w.trk;
                    end
                end
                if (w.last) close_frame(w.now);
            end
            default: ;   // unused kind is ignored
        endcase
    endfunction

    // ---------------------------------------------------------------- result side

    always @(negedge i_clk) begin
        result_bus.ready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_results
        t_frame_summary got;
        t_frame_summary want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            got.risk      = result_bus.max_risk;
            got.ttc       = result_bus.min_ttc_ms;
            got.near_dist = result_bus.nearest_distance_mm;
            got.near_cls  = result_bus.nearest_class;
            got.near_trk  = result_bus.nearest_track;
            got.alarm     = result_bus.alarm_active;
            if (frame_summaries_due.size() == 0) begin
                report_mismatch($sformatf("frame %0d: result word with none expected",
                                          frames_seen));
            end else begin
                want = frame_summaries_due.pop_front();
                if (got.risk !== want.risk)
                    report_mismatch($sformatf("frame %0d: max_risk %0d, expected %0d",
                                              frames_seen, got.risk, want.risk));
                if (got.ttc !== want.ttc)
                    report_mismatch($sformatf("frame %0d: min_ttc_ms %0d, expected %0d",
                                              frames_seen, got.ttc, want.ttc));
                if (got.near_dist !== want.near_dist)
                    report_mismatch($sformatf("frame %0d: nearest_distance %0d, expected %0d",
                                              frames_seen, got.near_dist, want.near_dist));
                if (got.near_cls !== want.near_cls)
                    report_mismatch($sformatf("frame %0d: nearest_class %0d, expected %0d",
                                              frames_seen, got.near_cls, want.near_cls));
                if (got.near_trk !== want.near_trk)
                    report_mismatch($sformatf("frame %0d: nearest_track %0d, expected %0d",
                                              frames_seen, got.near_trk, want.near_trk));
                if (got.alarm !== want.alarm)
                    report_mismatch($sformatf("frame %0d: alarm_active %0b, expected %0b",
                                              frames_seen, got.alarm, want.alarm));
            end
            frames_seen++;
        end
    end

    // ---------------------------------------------------------------- object side

    // Called at a falling edge; returns at the falling edge after the word is taken.
    // valid stays high into the next word unless that word idles first.
    task automatic send_word(t_track_word w);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            item_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid          = 1'b1;
        item_bus.kind           = w.kind;
        item_bus.distance_mm    = w.dist_mm;
        item_bus.pixel_velocity = w.vel;
        item_bus.obj_class      = w.cls;
        item_bus.obj_track      = w.trk;
        item_bus.last_in_frame  = w.last;
        item_bus.now_ms         = w.now;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        track_frame(w);
        @(negedge i_clk);
    endtask

    function automatic t_track_word track_word(logic [KIND_W-1:0] kind, int dist_mm,
                                               int vel, int unsigned cls,
                                               int unsigned trk,
                                               bit last, logic [TIME_W-1:0] now);
        t_track_word w;
        w.kind    = kind;
        w.dist_mm = SDIST_W'(dist_mm);
        w.vel     = VEL_W'(vel);
        w.cls     = CLASS_W'(cls);
        w.trk     = TRACK_W'(trk);
        w.last    = last;
        w.now     = now;
        return w;
    endfunction

    // Distances lean toward the threshold region; velocities mostly approaching.
    function automatic t_track_word random_object(bit last);
        t_track_word w;
        int unsigned pick;
        w.kind = KIND_OBJECT;
        pick = $urandom_range(99);
        if (pick < 8)       w.dist_mm = SDIST_W'(DIST_SKIP);
        else if (pick < 12) w.dist_mm = '0;
        else if (pick < 27) w.dist_mm = SDIST_W'($urandom_range(0, DIST_TOP));
        else                w.dist_mm = SDIST_W'($urandom_range(0, 8000));
        pick = $urandom_range(99);
        if (pick < 20)      w.vel = VEL_W'($urandom);
        else if (pick < 35) w.vel = VEL_W'($urandom_range(0, 400));
        else                w.vel = VEL_W'($urandom_range(1, 32767));
        w.cls  = CLASS_W'($urandom);
        w.trk  = TRACK_W'($urandom);
        w.last = last;
        w.now  = wall_ms;
        return w;
    endfunction

    // Block must be idle before a register write: all results in, plus the tail of
    // any object word still in the divider.
    task automatic wait_idle();
        item_bus.valid = 1'b0;
        while (frame_summaries_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- register port

    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        reg_shadow[idx] = (idx == REG_PPM || idx == REG_HOLD) ? value[CFG16_W-1:0]
                                                              : value[CFG20_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_regs();
        t_reg_idx idx;
        for (int i = 0; i < NUM_REGS; i++) begin
            idx     = t_reg_idx'(i);
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = 1'b0;
            paddr   = {idx, 2'b00};
            @(negedge i_clk);
            penable = 1'b1;
            @(posedge i_clk);
            if (prdata !== APB_DW'(reg_shadow[idx]))
                report_mismatch($sformatf("register %s reads %0d, expected %0d",
                                          idx.name(), prdata, reg_shadow[idx]));
            @(negedge i_clk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    task automatic apply_setting(int unsigned ppm, int unsigned hold,
                                 int unsigned t_crit, int unsigned t_dang,
                                 int unsigned t_warn, int unsigned t_caut,
                                 int unsigned d_crit, int unsigned d_caut);
        wait_idle();
        write_reg(REG_PPM, ppm);
        write_reg(REG_HOLD, hold);
        write_reg(REG_TTC_CRIT, t_crit);
        write_reg(REG_TTC_DANG, t_dang);
        write_reg(REG_TTC_WARN, t_warn);
        write_reg(REG_TTC_CAUT, t_caut);
        write_reg(REG_DIST_CRIT, d_crit);
        write_reg(REG_DIST_CAUT, d_caut);
        check_regs();
    endtask

    // ---------------------------------------------------------------- traffic

    // Random frames of 1..6 objects, with empty frames, force-off and unused kinds
    // mixed in between. Unused kinds are not counted.
    task automatic run_frames(int unsigned n_words);
        int unsigned sent;
        int unsigned n_obj;
        int unsigned pick;
        t_track_word w;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            wall_ms += (pick < 5) ? $urandom : $urandom_range(0, 900);
            w = random_object(1'($urandom_range(1)));
            if (pick < 6) begin
                w.kind = KIND_EMPTY;
                send_word(w);
                sent++;
            end else if (pick < 9) begin
                w.kind = KIND_FORCE_OFF;
                send_word(w);
                sent++;
            end else if (pick < 11) begin
                w.kind = KIND_UNUSED;
                send_word(w);
            end else begin
                n_obj = $urandom_range(1, 6);
                for (int i = 0; i < n_obj; i++) send_word(random_object(i == n_obj - 1));
                sent += n_obj;
            end
            // now and then hold back until every frame result is out
            if ($urandom_range(99) < 2) wait_idle();
        end
    endtask

    task automatic test_directed_frames();
        // reset settings: ppm 100, hold 2000 ms, critical distance 800 mm
        send_word(track_word(KIND_OBJECT, 0, 32767, 0, 0, 1, 32'd0));
        send_word(track_word(KIND_EMPTY, 0, 0, 0, 0, 0, 32'd1999));     // hold not over
        send_word(track_word(KIND_EMPTY, 0, 0, 0, 0, 0, 32'd2000));     // hold just over
        send_word(track_word(KIND_OBJECT, DIST_SKIP, 32767, 255, 65535, 1, 32'd2100));
        // one frame: largest distance receding, slow at the cap, caution-range object
        send_word(track_word(KIND_OBJECT, DIST_TOP, -32768, 255, 65535, 0, 32'd2200));
        send_word(track_word(KIND_OBJECT, 999000, 1, 1, 1, 0, 32'd2200));
        send_word(track_word(KIND_OBJECT, 4999, 32767, 8'hAA, 16'h5555, 0, 32'd2200));
        send_word(track_word(KIND_UNUSED, 0, 0, 0, 0, 1, 32'd2300));
        send_word(track_word(KIND_OBJECT, 1500, 0, 8'h55, 16'hAAAA, 1, 32'd3000));
        // critical near the wrap, forced off, then an empty frame after the wrap
        send_word(track_word(KIND_OBJECT, 799, 100, 3, 3, 1, 32'hFFFF_FF00));
        send_word(track_word(KIND_FORCE_OFF, 0, 0, 0, 0, 1, 32'hFFFF_FF01));
        send_word(track_word(KIND_EMPTY, 0, 0, 0, 0, 1, 32'h0000_0010));
        // hold release measured across the wrap
        send_word(track_word(KIND_OBJECT, 700, 5, 4, 4, 1, 32'hFFFF_FFFF));
        send_word(track_word(KIND_EMPTY, 0, 0, 0, 0, 0, 32'h0000_07CE));
        send_word(track_word(KIND_EMPTY, 0, 0, 0, 0, 0, 32'h0000_07CF));
        send_word(track_word(KIND_OBJECT, 3000, 50, 6, 6, 0, 32'd9000));
        send_word(track_word(KIND_OBJECT, 2999, -1, 7, 7, 1, 32'd9000));
        // smaller scale so every time grade can be reached
        wait_idle();
        write_reg(REG_PPM, 10);
        send_word(track_word(KIND_OBJECT, 6000, 12800, 10, 10, 1, 32'd10000));  // 1000 ms
        send_word(track_word(KIND_OBJECT, 6000, 6400, 11, 11, 1, 32'd10100));   // 2000 ms
        send_word(track_word(KIND_OBJECT, 6000, 3200, 12, 12, 1, 32'd10200));   // 4000 ms
        send_word(track_word(KIND_OBJECT, 6000, 2000, 13, 13, 1, 32'd10300));   // 6400 ms
        send_word(track_word(KIND_OBJECT, 6000, 1, 14, 14, 1, 32'd20000));      // too slow
    endtask

    task automatic test_register_extremes();
        // zero scale: no time to collision at all; every distance under 999000 mm below the limits
        apply_setting(0, 0, 999000, 999000, 999000, 999000, 999000, 999000);
        run_frames(60);
        // largest scale and hold, every programmable limit at zero
        apply_setting(65535, 65535, 0, 0, 0, 0, 0, 0);
        run_frames(60);
        // smallest scale with the time limits wide open
        apply_setting(1, 1, 999000, 999000, 999000, 999000, 0, 0);
        run_frames(60);
        // limits out of order
        apply_setting(5, 500, 6000, 100, 3000, 50, 2500, 400);
        run_frames(60);
    endtask

    task automatic test_random_traffic();
        int unsigned t_crit;
        int unsigned t_dang;
        int unsigned t_warn;
        int unsigned t_caut;
        for (int phase = 0; phase < 6; phase++) begin
            t_crit = $urandom_range(0, 3000);
            t_dang = t_crit + $urandom_range(0, 3000);
            t_warn = t_dang + $urandom_range(0, 3000);
            t_caut = t_warn + $urandom_range(0, 4000);
            apply_setting(($urandom_range(99) < 75) ? $urandom_range(1, 60)
                                                    : $urandom_range(1, 65535),
                          $urandom_range(0, 4000), t_crit, t_dang, t_warn, t_caut,
                          $urandom_range(0, 2000), $urandom_range(0, 9000));
            if (phase == 1) wall_ms = 32'hFFFF_F000;   // run the hold timer over the wrap
            steady_flow = (phase == 3);                 // long stretch with no idling
            run_frames(210);
            steady_flow = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_clk                   = 1'b0;
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        item_bus.valid          = 1'b0;
        item_bus.kind           = KIND_OBJECT;
        item_bus.distance_mm    = '0;
        item_bus.pixel_velocity = '0;
        item_bus.obj_class      = '0;
        item_bus.obj_track      = '0;
        item_bus.last_in_frame  = 1'b0;
        item_bus.now_ms         = '0;
        result_bus.ready        = 1'b0;
        steady_flow             = 1'b0;
        mismatch_count          = 0;
        frames_seen             = 0;
        wall_ms                 = '0;

        reg_shadow[REG_PPM]       = PPM_RST;
        reg_shadow[REG_HOLD]      = HOLD_RST;
        reg_shadow[REG_TTC_CRIT]  = TTC_CRIT_RST;
        reg_shadow[REG_TTC_DANG]  = TTC_DANG_RST;
        reg_shadow[REG_TTC_WARN]  = TTC_WARN_RST;
        reg_shadow[REG_TTC_CAUT]  = TTC_CAUT_RST;
        reg_shadow[REG_DIST_CRIT] = DIST_CRIT_RST;
        reg_shadow[REG_DIST_CAUT] = DIST_CAUT_RST;
        clear_frame();
        alarm_flag   = 1'b0;
        last_crit_ms = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        check_regs();              // reset values
        test_directed_frames();
        test_register_extremes();
        test_random_traffic();

        // all frames back, then a quiet tail to catch stray result words
        wait_idle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
